### rtl/core/stsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsl_pkg
// Shared widths, operation codes, register indexes and control structs of the
// two-axis servo slew limiter.
// ----------------------------------------------------------------------------
package stsl_pkg;

  localparam int ANGLE_W   = 15;
  localparam int PERIOD_W  = 16;
  localparam int OP_W      = 3;
  localparam int CMP_W     = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int ANGLE_FULL_SCALE_DEF = 18000;

  // clamp, period multiply, reciprocal multiply and saturate stages
  localparam int PIPE_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_BOTH  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_YAW   = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_PITCH = 3'd3;
  localparam logic [OP_W-1:0] OP_PLACE     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_YAW_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd5;

  localparam logic [ANGLE_W-1:0]  YAW_LOW_RST    = 15'd0;
  localparam logic [ANGLE_W-1:0]  YAW_HIGH_RST   = 15'd18000;
  localparam logic [ANGLE_W-1:0]  PITCH_LOW_RST  = 15'd0;
  localparam logic [ANGLE_W-1:0]  PITCH_HIGH_RST = 15'd18000;
  localparam logic [ANGLE_W-1:0]  STEP_RST       = 15'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd20000;

  typedef struct packed {
    logic [ANGLE_W-1:0]  yaw_low;
    logic [ANGLE_W-1:0]  yaw_high;
    logic [ANGLE_W-1:0]  pitch_low;
    logic [ANGLE_W-1:0]  pitch_high;
    logic [ANGLE_W-1:0]  step;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic en;        // whole pipeline advances
    logic acc;       // an item is taken this cycle
    logic tick;
    logic place;
    logic set_goal;
  } lane_ctrl_t;

  typedef struct packed {
    logic at_goal;   // slewed angle equals goal
  } lane_stat_t;

endpackage

### rtl/core/stsl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsl_in_if
// Command channel: operation code with yaw and pitch values.
// ----------------------------------------------------------------------------
interface stsl_in_if;
  logic                           valid;
  logic                           ready;
  logic [stsl_pkg::OP_W-1:0]      operation;
  logic [stsl_pkg::ANGLE_W-1:0]   yaw_value;
  logic [stsl_pkg::ANGLE_W-1:0]   pitch_value;

  modport source (output valid, output operation, output yaw_value, output pitch_value,
                  input ready);
  modport sink   (input valid, input operation, input yaw_value, input pitch_value,
                  output ready);
endinterface

### rtl/core/stsl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsl_out_if
// Result channel: PWM compare values, positions and done flag.
// ----------------------------------------------------------------------------
interface stsl_out_if;
  logic                           valid;
  logic                           ready;
  logic [stsl_pkg::CMP_W-1:0]     yaw_compare;
  logic [stsl_pkg::CMP_W-1:0]     pitch_compare;
  logic [stsl_pkg::ANGLE_W-1:0]   yaw_position;
  logic [stsl_pkg::ANGLE_W-1:0]   pitch_position;
  logic                           movement_done;

  modport source (output valid, output yaw_compare, output pitch_compare,
                  output yaw_position, output pitch_position, output movement_done,
                  input ready);
  modport sink   (input valid, input yaw_compare, input pitch_compare,
                  input yaw_position, input pitch_position, input movement_done,
                  output ready);
endinterface

### rtl/core/stsl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsl_cfg
// Configuration register file: axis limits, step size and PWM period.
// ----------------------------------------------------------------------------
module stsl_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [stsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stsl_pkg::CFG_DAT_W-1:0]    cfg_data,
  output stsl_pkg::cfg_t                    cfg
);

  stsl_pkg::cfg_t cfg_r;
  stsl_pkg::cfg_t cfg_nxt;
  logic [stsl_pkg::ANGLE_W-1:0] angle_data;

  assign angle_data = cfg_data[stsl_pkg::ANGLE_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        stsl_pkg::REG_YAW_LOW:    cfg_nxt.yaw_low    = angle_data;
        stsl_pkg::REG_YAW_HIGH:   cfg_nxt.yaw_high   = angle_data;
        stsl_pkg::REG_PITCH_LOW:  cfg_nxt.pitch_low  = angle_data;
        stsl_pkg::REG_PITCH_HIGH: cfg_nxt.pitch_high = angle_data;
        stsl_pkg::REG_STEP:       cfg_nxt.step       = angle_data;
        stsl_pkg::REG_PERIOD:     cfg_nxt.period     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yaw_low    <= stsl_pkg::YAW_LOW_RST;
      cfg_r.yaw_high   <= stsl_pkg::YAW_HIGH_RST;
      cfg_r.pitch_low  <= stsl_pkg::PITCH_LOW_RST;
      cfg_r.pitch_high <= stsl_pkg::PITCH_HIGH_RST;
      cfg_r.step       <= stsl_pkg::STEP_RST;
      cfg_r.period     <= stsl_pkg::PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/stsl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsl_lane
// One servo axis: position and goal state, slew step, limit clamp, and a
// pipelined compare computation (multiply, then reciprocal multiply by a constant).
// ----------------------------------------------------------------------------
module stsl_lane #(
  parameter int ANGLE_FULL_SCALE = stsl_pkg::ANGLE_FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stsl_pkg::lane_ctrl_t              ctrl,
  input  logic [stsl_pkg::ANGLE_W-1:0]      value,
  input  logic [stsl_pkg::ANGLE_W-1:0]      low,
  input  logic [stsl_pkg::ANGLE_W-1:0]      high,
  input  logic [stsl_pkg::ANGLE_W-1:0]      step,
  input  logic [stsl_pkg::PERIOD_W-1:0]     period,
  output stsl_pkg::lane_stat_t              stat,
  output logic [stsl_pkg::CMP_W-1:0]        compare,
  output logic [stsl_pkg::ANGLE_W-1:0]      position
);

  localparam int AW      = stsl_pkg::ANGLE_W;
  localparam int CW      = stsl_pkg::CMP_W;
  localparam int DEPTH   = stsl_pkg::PIPE_DEPTH;
  localparam longint SUM_MAX = longint'(ANGLE_FULL_SCALE) + 4 * ((longint'(1) << AW) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int NUM_W   = stsl_pkg::PERIOD_W + SUM_W;
  // 40 * full scale = 8 * (5 * full scale): drop three bits, then an exact
  // reciprocal multiply for the remaining factor
  localparam int NW      = NUM_W - 3;
  localparam longint DEN5 = 5 * longint'(ANGLE_FULL_SCALE);
  localparam int LOG_W   = $clog2(DEN5);
  localparam int SHIFT   = NW + LOG_W;
  localparam int M_W     = NW + 1;
  localparam int PROD_W  = NW + M_W;
  localparam longint RECIP = ((longint'(1) << SHIFT) + DEN5 - 1) / DEN5;

  localparam logic [SUM_W-1:0] FS_SUM  = SUM_W'(ANGLE_FULL_SCALE);
  localparam logic [M_W-1:0]   RECIP_C = M_W'(RECIP);

  function automatic logic [AW-1:0] clamp_to(input logic [AW-1:0] v,
                                              input logic [AW-1:0] lo,
                                              input logic [AW-1:0] hi);
    logic [AW-1:0] t;
    t = (v > hi) ? hi : v;
    return (t < lo) ? lo : t;
  endfunction

  // axis state
  logic [AW-1:0] angle_r, angle_nxt;
  logic [AW-1:0] goal_r, goal_nxt;
  logic [AW-1:0] slewed;

  always_comb begin
    slewed = angle_r;
    if (goal_r > angle_r) begin
      slewed = (goal_r - angle_r <= step) ? goal_r : angle_r + step;
    end else if (angle_r > goal_r) begin
      slewed = (angle_r - goal_r <= step) ? goal_r : angle_r - step;
    end
  end

  always_comb begin
    angle_nxt = angle_r;
    goal_nxt  = goal_r;
    if (ctrl.acc) begin
      if (ctrl.tick) begin
        angle_nxt = slewed;
      end
      if (ctrl.place) begin
        angle_nxt = value;
        goal_nxt  = value;
      end
      if (ctrl.set_goal) begin
        goal_nxt = clamp_to(value, low, high);
      end
    end
  end

  assign stat.at_goal = (slewed == goal_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      goal_r  <= '0;
    end else begin
      angle_r <= angle_nxt;
      goal_r  <= goal_nxt;
    end
  end

  // compare pipeline
  logic [AW-1:0]     cl_r;
  logic [NUM_W-1:0]  num_r;
  logic [PROD_W-1:0] prod_r;
  logic [CW-1:0]     cmp_r;
  logic [AW-1:0]     pos_r [0:DEPTH-1];
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] quot;
  logic [CW-1:0]     cmp_nxt;

  assign sum  = FS_SUM + {{(SUM_W - AW - 2){1'b0}}, cl_r, 2'b00};
  assign quot = prod_r >> SHIFT;
  // quotient beyond the compare width saturates
  assign cmp_nxt = (|quot[PROD_W-1:CW]) ? '1 : quot[CW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      cl_r     <= clamp_to(angle_nxt, low, high);
      num_r    <= NUM_W'(period) * NUM_W'(sum);
      prod_r   <= PROD_W'(num_r[NUM_W-1:3]) * PROD_W'(RECIP_C);
      cmp_r    <= cmp_nxt;
      pos_r[0] <= angle_nxt;
      for (int s = 1; s < DEPTH; s++) begin
        pos_r[s] <= pos_r[s-1];
      end
    end
  end

  assign compare  = cmp_r;
  assign position = pos_r[DEPTH-1];

endmodule

### rtl/core/stsl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsl_merge
// Operation decode, pipeline flow control, and the done flag that combines
// what both axis lanes report.
// ----------------------------------------------------------------------------
module stsl_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [stsl_pkg::OP_W-1:0]         op,
  output logic                              in_ready,
  input  logic                              out_ready,
  output logic                              out_valid,
  input  stsl_pkg::lane_stat_t              yaw_stat,
  input  stsl_pkg::lane_stat_t              pitch_stat,
  output stsl_pkg::lane_ctrl_t              yaw_ctrl,
  output stsl_pkg::lane_ctrl_t              pitch_ctrl,
  output logic                              done
);

  localparam int DEPTH = stsl_pkg::PIPE_DEPTH;

  logic en, acc;
  logic tick, place, set_yaw, set_pitch;
  logic done_r, done_nxt;
  logic [DEPTH-1:0] v_r;
  logic             d_r [0:DEPTH-1];

  // the whole pipeline freezes while the last stage holds an untaken item
  assign en  = !v_r[DEPTH-1] || out_ready;
  assign acc = in_valid && en;

  always_comb begin
    tick      = 1'b0;
    place     = 1'b0;
    set_yaw   = 1'b0;
    set_pitch = 1'b0;
    case (op)
      stsl_pkg::OP_TICK:      tick = 1'b1;
      stsl_pkg::OP_SET_BOTH:  begin
        set_yaw   = 1'b1;
        set_pitch = 1'b1;
      end
      stsl_pkg::OP_SET_YAW:   set_yaw = 1'b1;
      stsl_pkg::OP_SET_PITCH: set_pitch = 1'b1;
      stsl_pkg::OP_PLACE:     place = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    done_nxt = done_r;
    if (acc) begin
      if (tick && yaw_stat.at_goal && pitch_stat.at_goal) begin
        done_nxt = 1'b1;
      end
      if (set_yaw || set_pitch) begin
        done_nxt = 1'b0;
      end
      if (place) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
      v_r    <= '0;
    end else begin
      done_r <= done_nxt;
      if (en) begin
        v_r <= {v_r[DEPTH-2:0], acc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= done_nxt;
      for (int s = 1; s < DEPTH; s++) begin
        d_r[s] <= d_r[s-1];
      end
    end
  end

  always_comb begin
    yaw_ctrl.en         = en;
    yaw_ctrl.acc        = acc;
    yaw_ctrl.tick       = tick;
    yaw_ctrl.place      = place;
    yaw_ctrl.set_goal   = set_yaw;
    pitch_ctrl.en       = en;
    pitch_ctrl.acc      = acc;
    pitch_ctrl.tick     = tick;
    pitch_ctrl.place    = place;
    pitch_ctrl.set_goal = set_pitch;
  end

  assign in_ready  = en;
  assign out_valid = v_r[DEPTH-1];
  assign done      = d_r[DEPTH-1];

endmodule

### rtl/core/two_axis_servo_slew_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_servo_slew_limiter
// Yaw and pitch servo slewer with limit clamps and PWM compare outputs.
//
//   port     direction  contents
//   in_ch    sink       operation, yaw_value, pitch_value
//   out_ch   source     yaw/pitch compare, yaw/pitch position, movement_done
//   cfg_*    input      write enable, register index, write data
//
// One item per cycle while out_ch takes results; each taken item passes through
// the clamp, period multiply, reciprocal multiply and saturate stages.
// Axis state updates in the cycle an item is taken, so items follow back to back.
// Synchronous reset restores registers and state; no clearing pass.
// While a result waits at the output, the pipeline holds and in_ch.ready drops.
// ----------------------------------------------------------------------------
module two_axis_servo_slew_limiter #(
  parameter int ANGLE_FULL_SCALE = stsl_pkg::ANGLE_FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  stsl_in_if.sink                           in_ch,
  stsl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [stsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stsl_pkg::CFG_DAT_W-1:0]    cfg_data
);

  stsl_pkg::cfg_t       cfg;
  stsl_pkg::lane_ctrl_t yaw_ctrl, pitch_ctrl;
  stsl_pkg::lane_stat_t yaw_stat, pitch_stat;
  logic                 in_ready, out_valid, done;

  stsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stsl_lane #(.ANGLE_FULL_SCALE(ANGLE_FULL_SCALE)) u_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (yaw_ctrl),
    .value    (in_ch.yaw_value),
    .low      (cfg.yaw_low),
    .high     (cfg.yaw_high),
    .step     (cfg.step),
    .period   (cfg.period),
    .stat     (yaw_stat),
    .compare  (out_ch.yaw_compare),
    .position (out_ch.yaw_position)
  );

  stsl_lane #(.ANGLE_FULL_SCALE(ANGLE_FULL_SCALE)) u_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (pitch_ctrl),
    .value    (in_ch.pitch_value),
    .low      (cfg.pitch_low),
    .high     (cfg.pitch_high),
    .step     (cfg.step),
    .period   (cfg.period),
    .stat     (pitch_stat),
    .compare  (out_ch.pitch_compare),
    .position (out_ch.pitch_position)
  );

  stsl_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .op         (in_ch.operation),
    .in_ready   (in_ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_valid),
    .yaw_stat   (yaw_stat),
    .pitch_stat (pitch_stat),
    .yaw_ctrl   (yaw_ctrl),
    .pitch_ctrl (pitch_ctrl),
    .done       (done)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.movement_done = done;

endmodule

### dv/tb_two_axis_servo_slew_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_axis_servo_slew_limiter
// Self-checking bench for the yaw/pitch servo slewer. A short directed run
// covers the corner cases: limits, snapping, zero step, inverted limits,
// spare opcodes. Then limit, step and period settings change phase by phase
// under random commands. Every item on the command channel is scored against
// an in-bench copy of the slew state, and each reported item is checked field
// by field. Both channels stall at random, with one long stall on the report
// side.
// ----------------------------------------------------------------------------
module tb_two_axis_servo_slew_limiter;

  localparam int FULL_SCALE  = stsl_pkg::ANGLE_FULL_SCALE_DEF;
  localparam int CMP_MAX     = (1 << stsl_pkg::CMP_W) - 1;
  localparam int ANGLE_MAX   = (1 << stsl_pkg::ANGLE_W) - 1;
  localparam int LONG_HOLD   = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 107;
  localparam int PHASE_COUNT = 10;

  // opcodes the block leaves unused
  localparam logic [stsl_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [stsl_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [stsl_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [stsl_pkg::OP_W-1:0]    op;
    logic [stsl_pkg::ANGLE_W-1:0] yaw;
    logic [stsl_pkg::ANGLE_W-1:0] pitch;
  } servo_cmd_t;

  typedef struct packed {
    logic [stsl_pkg::CMP_W-1:0]   yaw_cmp;
    logic [stsl_pkg::CMP_W-1:0]   pitch_cmp;
    logic [stsl_pkg::ANGLE_W-1:0] yaw_pos;
    logic [stsl_pkg::ANGLE_W-1:0] pitch_pos;
    logic                         done;
  } servo_report_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [stsl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [stsl_pkg::CFG_DAT_W-1:0] cfg_data;

  stsl_in_if  cmd_if ();
  stsl_out_if rpt_if ();

  two_axis_servo_slew_limiter #(
    .ANGLE_FULL_SCALE(FULL_SCALE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_if),
    .out_ch   (rpt_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // bench copy of registers and axis state
  logic [stsl_pkg::ANGLE_W-1:0]  yaw_lo_r, yaw_hi_r, pitch_lo_r, pitch_hi_r, step_r;
  logic [stsl_pkg::PERIOD_W-1:0] period_r;
  logic [stsl_pkg::ANGLE_W-1:0]  yaw_now, pitch_now, yaw_goal_m, pitch_goal_m;
  logic                          done_m;

  servo_cmd_t    cmd_queue[$];
  servo_report_t expected_reports[$];
  servo_cmd_t    on_bus;

  int   mismatch_count;
  int   src_gap;
  int   sink_gap;
  int   idle_cycles;
  int   rx_hold_left;
  logic rx_hold_taken;
  logic rx_hold_req;
  logic src_idle_en;
  logic sink_idle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [stsl_pkg::ANGLE_W-1:0] clamp_angle(
      input logic [stsl_pkg::ANGLE_W-1:0] v,
      input logic [stsl_pkg::ANGLE_W-1:0] lo,
      input logic [stsl_pkg::ANGLE_W-1:0] hi);
    logic [stsl_pkg::ANGLE_W-1:0] c;
    c = v;
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    return c;
  endfunction

  function automatic logic [stsl_pkg::CMP_W-1:0] pwm_compare(
      input logic [stsl_pkg::ANGLE_W-1:0] a);
    logic [63:0] num;
    logic [63:0] q;
    num = 64'(period_r) * (64'(FULL_SCALE) + 64'(a) * 64'd4);
    q   = num / (64'd40 * 64'(FULL_SCALE));
    if (q > 64'(CMP_MAX)) q = 64'(CMP_MAX);
    return q[stsl_pkg::CMP_W-1:0];
  endfunction

  function automatic logic [stsl_pkg::ANGLE_W-1:0] slew_toward(
      input logic [stsl_pkg::ANGLE_W-1:0] pos,
      input logic [stsl_pkg::ANGLE_W-1:0] goal);
    if (goal > pos) return (goal - pos <= step_r) ? goal : pos + step_r;
    if (pos > goal) return (pos - goal <= step_r) ? goal : pos - step_r;
    return pos;
  endfunction

  task automatic apply_servo_cmd(input servo_cmd_t c);
    servo_report_t r;
    case (c.op)
      stsl_pkg::OP_TICK: begin
        yaw_now   = slew_toward(yaw_now, yaw_goal_m);
        pitch_now = slew_toward(pitch_now, pitch_goal_m);
        if (yaw_now == yaw_goal_m && pitch_now == pitch_goal_m) done_m = 1'b1;
      end
      stsl_pkg::OP_SET_BOTH: begin
        yaw_goal_m   = clamp_angle(c.yaw, yaw_lo_r, yaw_hi_r);
        pitch_goal_m = clamp_angle(c.pitch, pitch_lo_r, pitch_hi_r);
        done_m       = 1'b0;
      end
      stsl_pkg::OP_SET_YAW: begin
        yaw_goal_m = clamp_angle(c.yaw, yaw_lo_r, yaw_hi_r);
        done_m     = 1'b0;
      end
      stsl_pkg::OP_SET_PITCH: begin
        pitch_goal_m = clamp_angle(c.pitch, pitch_lo_r, pitch_hi_r);
        done_m       = 1'b0;
      end
      stsl_pkg::OP_PLACE: begin
        // placement bypasses the limits, only the compare sees them
        yaw_now      = c.yaw;
        pitch_now    = c.pitch;
        yaw_goal_m   = c.yaw;
        pitch_goal_m = c.pitch;
        done_m       = 1'b1;
      end
      default: ;
    endcase
    r.yaw_cmp   = pwm_compare(clamp_angle(yaw_now, yaw_lo_r, yaw_hi_r));
    r.pitch_cmp = pwm_compare(clamp_angle(pitch_now, pitch_lo_r, pitch_hi_r));
    r.yaw_pos   = yaw_now;
    r.pitch_pos = pitch_now;
    r.done      = done_m;
    expected_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic score_report(input servo_report_t got);
    servo_report_t want;
    if (expected_reports.size() == 0) begin
      $error("report item with nothing pending: yaw_position %0d pitch_position %0d",
             got.yaw_pos, got.pitch_pos);
      mismatch_count++;
    end else begin
      want = expected_reports.pop_front();
      check_field("yaw_compare", want.yaw_cmp, got.yaw_cmp);
      check_field("pitch_compare", want.pitch_cmp, got.pitch_cmp);
      check_field("yaw_position", want.yaw_pos, got.yaw_pos);
      check_field("pitch_position", want.pitch_pos, got.pitch_pos);
      check_field("movement_done", want.done, got.done);
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.valid       <= 1'b0;
      cmd_if.operation   <= '0;
      cmd_if.yaw_value   <= '0;
      cmd_if.pitch_value <= '0;
      src_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) apply_servo_cmd(on_bus);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          cmd_if.valid <= 1'b0;
        end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 18);
          cmd_if.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          on_bus = cmd_queue.pop_front();
          cmd_if.operation   <= on_bus.op;
          cmd_if.yaw_value   <= on_bus.yaw;
          cmd_if.pitch_value <= on_bus.pitch;
          cmd_if.valid       <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // long report-side stall, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left  <= 0;
      rx_hold_taken <= 1'b0;
    end else if (rx_hold_req && !rx_hold_taken) begin
      rx_hold_left  <= LONG_HOLD;
      rx_hold_taken <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // report monitor
  always @(posedge clk) begin : report_side
    servo_report_t got;
    logic          next_ready;
    if (!rst_n) begin
      rpt_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (rpt_if.valid && rpt_if.ready) begin
        got.yaw_cmp   = rpt_if.yaw_compare;
        got.pitch_cmp = rpt_if.pitch_compare;
        got.yaw_pos   = rpt_if.yaw_position;
        got.pitch_pos = rpt_if.pitch_position;
        got.done      = rpt_if.movement_done;
        score_report(got);
      end
      if (rx_hold_left != 0) begin
        next_ready = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        next_ready = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 18);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      rpt_if.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [stsl_pkg::OP_W-1:0] op, input int unsigned yaw,
                          input int unsigned pitch);
    servo_cmd_t c;
    c.op    = op;
    c.yaw   = yaw[stsl_pkg::ANGLE_W-1:0];
    c.pitch = pitch[stsl_pkg::ANGLE_W-1:0];
    cmd_queue.push_back(c);
  endtask

  task automatic write_reg(input logic [stsl_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    logic [stsl_pkg::CFG_DAT_W-1:0] d;
    d = val[stsl_pkg::CFG_DAT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      stsl_pkg::REG_YAW_LOW:    yaw_lo_r   = d[stsl_pkg::ANGLE_W-1:0];
      stsl_pkg::REG_YAW_HIGH:   yaw_hi_r   = d[stsl_pkg::ANGLE_W-1:0];
      stsl_pkg::REG_PITCH_LOW:  pitch_lo_r = d[stsl_pkg::ANGLE_W-1:0];
      stsl_pkg::REG_PITCH_HIGH: pitch_hi_r = d[stsl_pkg::ANGLE_W-1:0];
      stsl_pkg::REG_STEP:       step_r     = d[stsl_pkg::ANGLE_W-1:0];
      stsl_pkg::REG_PERIOD:     period_r   = d;
      default: ;
    endcase
  endtask

  // angle registers get a random bit 15 that the block must drop
  task automatic load_settings(input int unsigned ylo, input int unsigned yhi,
                               input int unsigned plo, input int unsigned phi,
                               input int unsigned step, input int unsigned period);
    write_reg(stsl_pkg::REG_YAW_LOW,    ylo  | ($urandom_range(0, 1) << stsl_pkg::ANGLE_W));
    write_reg(stsl_pkg::REG_YAW_HIGH,   yhi  | ($urandom_range(0, 1) << stsl_pkg::ANGLE_W));
    write_reg(stsl_pkg::REG_PITCH_LOW,  plo  | ($urandom_range(0, 1) << stsl_pkg::ANGLE_W));
    write_reg(stsl_pkg::REG_PITCH_HIGH, phi  | ($urandom_range(0, 1) << stsl_pkg::ANGLE_W));
    write_reg(stsl_pkg::REG_STEP,       step | ($urandom_range(0, 1) << stsl_pkg::ANGLE_W));
    write_reg(stsl_pkg::REG_PERIOD,     period);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    while (cmd_queue.size() != 0 || cmd_if.valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  function automatic int unsigned pick_angle(input int center, input int spread,
                                             input int unsigned lo, input int unsigned hi);
    int v;
    case ($urandom_range(0, 15))
      0: return $urandom_range(0, ANGLE_MAX);
      1: return 0;
      2: return ANGLE_MAX;
      3: return lo;
      4: return hi;
      default: begin
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > ANGLE_MAX) v = ANGLE_MAX;
        return v;
      end
    endcase
  endfunction

  // mostly targets a few steps away so axes settle and the done flag moves
  task automatic queue_random_cmds(input int n);
    int                         yc, pc, spread, r;
    logic [stsl_pkg::OP_W-1:0]  op;
    yc = 0;
    pc = 0;
    spread = (step_r == 0) ? 40 : ((int'(step_r) * 6 > 20000) ? 20000 : int'(step_r) * 6);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        yc = $urandom_range(0, FULL_SCALE);
        pc = $urandom_range(0, FULL_SCALE);
      end
      r = $urandom_range(0, 99);
      if (r < 50)      op = stsl_pkg::OP_TICK;
      else if (r < 62) op = stsl_pkg::OP_SET_BOTH;
      else if (r < 70) op = stsl_pkg::OP_SET_YAW;
      else if (r < 78) op = stsl_pkg::OP_SET_PITCH;
      else if (r < 92) op = stsl_pkg::OP_PLACE;
      else begin
        case ($urandom_range(0, 2))
          0:       op = OP_SPARE_5;
          1:       op = OP_SPARE_6;
          default: op = OP_SPARE_7;
        endcase
      end
      push_cmd(op, pick_angle(yc, spread, yaw_lo_r, yaw_hi_r),
               pick_angle(pc, spread, pitch_lo_r, pitch_hi_r));
    end
  endtask

  initial begin
    int unsigned lo, hi;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    mismatch_count = 0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    rx_hold_req    = 1'b0;
    yaw_lo_r     = stsl_pkg::YAW_LOW_RST;
    yaw_hi_r     = stsl_pkg::YAW_HIGH_RST;
    pitch_lo_r   = stsl_pkg::PITCH_LOW_RST;
    pitch_hi_r   = stsl_pkg::PITCH_HIGH_RST;
    step_r       = stsl_pkg::STEP_RST;
    period_r     = stsl_pkg::PERIOD_RST;
    yaw_now      = '0;
    pitch_now    = '0;
    yaw_goal_m   = '0;
    pitch_goal_m = '0;
    done_m       = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: out-of-limit placement, snapping, spare opcodes
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    push_cmd(stsl_pkg::OP_PLACE, ANGLE_MAX, ANGLE_MAX);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    push_cmd(stsl_pkg::OP_PLACE, 0, 0);
    push_cmd(stsl_pkg::OP_SET_BOTH, 15, 4);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    push_cmd(stsl_pkg::OP_SET_YAW, ANGLE_MAX, 0);
    push_cmd(stsl_pkg::OP_SET_PITCH, ANGLE_MAX, 0);
    push_cmd(OP_SPARE_5, 123, 456);
    push_cmd(OP_SPARE_6, ANGLE_MAX, 0);
    push_cmd(OP_SPARE_7, 0, ANGLE_MAX);
    push_cmd(stsl_pkg::OP_PLACE, FULL_SCALE, FULL_SCALE);
    push_cmd(stsl_pkg::OP_SET_BOTH, FULL_SCALE - 5, FULL_SCALE);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    push_cmd(stsl_pkg::OP_PLACE, FULL_SCALE - 10, 9);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    wait_drained();

    // inverted yaw limits (low wins), zero step, widest period
    load_settings(300, 200, 0, ANGLE_MAX, 0, 65535);
    push_cmd(stsl_pkg::OP_PLACE, 250, ANGLE_MAX);
    push_cmd(stsl_pkg::OP_SET_YAW, 100, 0);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    push_cmd(stsl_pkg::OP_PLACE, 300, 5);
    push_cmd(stsl_pkg::OP_SET_BOTH, 100, 5);
    push_cmd(stsl_pkg::OP_TICK, 0, 0);
    wait_drained();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: load_settings(stsl_pkg::YAW_LOW_RST, stsl_pkg::YAW_HIGH_RST,
                         stsl_pkg::PITCH_LOW_RST, stsl_pkg::PITCH_HIGH_RST,
                         stsl_pkg::STEP_RST, stsl_pkg::PERIOD_RST);
        1: load_settings(0, ANGLE_MAX, 0, ANGLE_MAX, 1, 65535);
        2: load_settings(0, 0, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, 1);
        3: load_settings($urandom_range(0, ANGLE_MAX), $urandom_range(0, ANGLE_MAX),
                         $urandom_range(0, ANGLE_MAX), $urandom_range(0, ANGLE_MAX),
                         $urandom_range(1, 500), $urandom_range(0, 65535));
        4: load_settings(9000, 3000, 12000, 500, 37, 40000);
        6: load_settings($urandom_range(0, 9000), $urandom_range(9000, FULL_SCALE),
                         $urandom_range(0, 9000), $urandom_range(9000, FULL_SCALE),
                         0, 50000);
        default: begin
          lo = $urandom_range(0, 9000);
          hi = $urandom_range(9000, FULL_SCALE);
          load_settings(lo, hi, $urandom_range(0, 9000), $urandom_range(9000, FULL_SCALE),
                        $urandom_range(1, 200), $urandom_range(1000, 65535));
        end
      endcase
      if (phase == 4) begin
        // sender keeps offering while the report side holds off
        src_idle_en = 1'b0;
        rx_hold_req = 1'b1;
      end
      if (phase == PHASE_COUNT - 1) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      queue_random_cmds(PHASE_ITEMS);
      wait_drained();
      if (phase != PHASE_COUNT - 1) src_idle_en = 1'b1;
    end

    repeat (stsl_pkg::PIPE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
